// ===== rtl/akd_pkg.sv =====
// ----------------------------------------------------------------------------
// akd_pkg: shared types and constants for the analog keypad debouncer
// Payload structs, button and key state codes, register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package akd_pkg;

    // button codes
    localparam logic [2:0] KEY_NONE   = 3'd0;
    localparam logic [2:0] KEY_RIGHT  = 3'd1;
    localparam logic [2:0] KEY_UP     = 3'd2;
    localparam logic [2:0] KEY_DOWN   = 3'd3;
    localparam logic [2:0] KEY_LEFT   = 3'd4;
    localparam logic [2:0] KEY_SELECT = 3'd5;

    // key state codes
    localparam logic [1:0] ST_RELEASED = 2'd0;
    localparam logic [1:0] ST_PRESSED  = 2'd1;
    localparam logic [1:0] ST_HELD     = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_HOLD_TIME  = 3'd0;
    localparam logic [2:0] REG_STABLE_TOL = 3'd1;
    localparam logic [2:0] REG_STABLE_NED = 3'd2;
    localparam logic [2:0] REG_NONE_CUT   = 3'd3;
    localparam logic [2:0] REG_RIGHT_CUT  = 3'd4;
    localparam logic [2:0] REG_UP_CUT     = 3'd5;
    localparam logic [2:0] REG_DOWN_CUT   = 3'd6;
    localparam logic [2:0] REG_LEFT_CUT   = 3'd7;

    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;

    // register reset values
    localparam logic [15:0] RST_HOLD_TIME  = 16'd1000;
    localparam logic [11:0] RST_STABLE_TOL = 12'd10;
    localparam logic [7:0]  RST_STABLE_NED = 8'd3;
    localparam logic [11:0] RST_NONE_CUT   = 12'd4050;
    localparam logic [11:0] RST_RIGHT_CUT  = 12'd200;
    localparam logic [11:0] RST_UP_CUT     = 12'd1800;
    localparam logic [11:0] RST_DOWN_CUT   = 12'd2800;
    localparam logic [11:0] RST_LEFT_CUT   = 12'd3600;

    localparam logic [7:0] RUN_MAX = 8'd255;

    typedef struct packed {
        logic [11:0] adc_sample;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [2:0]  press_event;
        logic [1:0]  key_state;
        logic [2:0]  active_button;
        logic [11:0] average_level;
    } t_out;

    typedef struct packed {
        logic [11:0] none_cut;
        logic [11:0] right_cut;
        logic [11:0] up_cut;
        logic [11:0] down_cut;
        logic [11:0] left_cut;
    } t_cutoffs;

    // fixed priority: none, right, up, down, left, then select
    function automatic logic [2:0] classify(input logic [11:0] level, input t_cutoffs cut);
        logic [2:0] btn;
        if (level > cut.none_cut) begin
            btn = KEY_NONE;
        end else if (level < cut.right_cut) begin
            btn = KEY_RIGHT;
        end else if (level < cut.up_cut) begin
            btn = KEY_UP;
        end else if (level < cut.down_cut) begin
            btn = KEY_DOWN;
        end else if (level < cut.left_cut) begin
            btn = KEY_LEFT;
        end else begin
            btn = KEY_SELECT;
        end
        return btn;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/analog_keypad_debouncer_top.sv =====
// ----------------------------------------------------------------------------
// analog_keypad_debouncer_top: resistor-ladder keypad debouncer
// Moving average of ADC samples, button classification, stability count and
// a released/pressed/held machine with one press event per press.
// ----------------------------------------------------------------------------
// Takes one ADC sample per cycle unless the output side stalls, and returns one
// result per sample, in order, through three registered stages: the running
// sum is updated as the request is taken, the next stage divides it by
// AVERAGE_DEPTH through a reciprocal multiply, and the last stage classifies
// the average and steps the stability count and key state into the output
// register. Output stalls back up through the three stages. The sample window is a
// shift line of AVERAGE_DEPTH entries cleared at reset. The user must write
// registers via the APB port only while no request is in flight; not enforced.
`default_nettype none

module analog_keypad_debouncer_top
    import akd_pkg::*;
#(
    parameter int unsigned AVERAGE_DEPTH = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in                i_in_data,

    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out                    o_out_data,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int unsigned DEPTH_LOG = $clog2(AVERAGE_DEPTH);
    localparam int unsigned SUM_W     = 12 + DEPTH_LOG;
    localparam int unsigned SHIFT     = SUM_W + DEPTH_LOG;
    localparam int unsigned MUL_W     = SUM_W + 2;
    localparam int unsigned PROD_W    = SUM_W + MUL_W;
    // ceil(2^SHIFT / depth): exact floor division for any SUM_W-bit sum
    localparam logic [MUL_W-1:0] RECIP =
        MUL_W'(((64'd1 << SHIFT) + 64'(AVERAGE_DEPTH) - 64'd1) / 64'(AVERAGE_DEPTH));

    // ---------------- configuration ----------------
    logic [15:0] r_hold_time;
    logic [11:0] r_stable_tol;
    logic [7:0]  r_stable_ned;
    t_cutoffs    r_cut;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time     <= RST_HOLD_TIME;
            r_stable_tol    <= RST_STABLE_TOL;
            r_stable_ned    <= RST_STABLE_NED;
            r_cut.none_cut  <= RST_NONE_CUT;
            r_cut.right_cut <= RST_RIGHT_CUT;
            r_cut.up_cut    <= RST_UP_CUT;
            r_cut.down_cut  <= RST_DOWN_CUT;
            r_cut.left_cut  <= RST_LEFT_CUT;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_HOLD_TIME:  r_hold_time     <= pwdata[15:0];
                REG_STABLE_TOL: r_stable_tol    <= pwdata[11:0];
                REG_STABLE_NED: r_stable_ned    <= pwdata[7:0];
                REG_NONE_CUT:   r_cut.none_cut  <= pwdata[11:0];
                REG_RIGHT_CUT:  r_cut.right_cut <= pwdata[11:0];
                REG_UP_CUT:     r_cut.up_cut    <= pwdata[11:0];
                REG_DOWN_CUT:   r_cut.down_cut  <= pwdata[11:0];
                REG_LEFT_CUT:   r_cut.left_cut  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HOLD_TIME:  prdata = {16'd0, r_hold_time};
            REG_STABLE_TOL: prdata = {20'd0, r_stable_tol};
            REG_STABLE_NED: prdata = {24'd0, r_stable_ned};
            REG_NONE_CUT:   prdata = {20'd0, r_cut.none_cut};
            REG_RIGHT_CUT:  prdata = {20'd0, r_cut.right_cut};
            REG_UP_CUT:     prdata = {20'd0, r_cut.up_cut};
            REG_DOWN_CUT:   prdata = {20'd0, r_cut.down_cut};
            REG_LEFT_CUT:   prdata = {20'd0, r_cut.left_cut};
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline flow ----------------
    logic r_a_valid, r_b_valid, r_out_valid;
    logic out_load, b_load_ok, b_adv, a_adv, in_fire;

    assign out_load   = !r_out_valid || i_out_ready;
    assign b_load_ok  = !r_b_valid || out_load;
    assign b_adv      = r_b_valid && out_load;
    assign a_adv      = r_a_valid && b_load_ok;
    assign o_in_ready = !r_a_valid || b_load_ok;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (b_load_ok) begin
                r_b_valid <= r_a_valid;
            end
            if (out_load) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    // ---------------- stage A: window and running sum ----------------
    logic [11:0]      r_ring [AVERAGE_DEPTH];
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [31:0]      r_a_now;

    // oldest sample sits at the end of the shift line
    assign n_sum = r_sum - SUM_W'(r_ring[AVERAGE_DEPTH-1]) + SUM_W'(i_in_data.adc_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AVERAGE_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
            r_sum <= '0;
        end else if (in_fire) begin
            r_ring[0] <= i_in_data.adc_sample;
            for (int k = 1; k < AVERAGE_DEPTH; k++) begin
                r_ring[k] <= r_ring[k-1];
            end
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_now <= i_in_data.now_ms;
        end
    end

    // ---------------- stage B: divide by depth ----------------
    logic [PROD_W-1:0] r_b_prod;
    logic [31:0]       r_b_now;

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_prod <= PROD_W'(r_sum) * PROD_W'(RECIP);
            r_b_now  <= r_a_now;
        end
    end

    // ---------------- stage C: classify, stability, key state ----------------
    logic [11:0] r_ref_level;
    logic        r_ref_valid;
    logic [2:0]  r_ref_button;
    logic [7:0]  r_run;
    logic [1:0]  r_state;
    logic [2:0]  r_held;
    logic [31:0] r_start;
    t_out        r_out;

    logic [11:0] avg;
    logic [2:0]  det;
    logic [11:0] diff;
    logic [11:0] n_ref_level;
    logic [2:0]  n_ref_button;
    logic [7:0]  n_run;
    logic [1:0]  n_state;
    logic [2:0]  n_held;
    logic [31:0] n_start;
    logic [2:0]  n_event;
    logic [31:0] elapsed;
    logic        lost;

    assign avg     = r_b_prod[SHIFT +: 12];
    assign det     = classify(avg, r_cut);
    assign diff    = (avg > r_ref_level) ? (avg - r_ref_level) : (r_ref_level - avg);
    assign elapsed = r_b_now - r_start;
    assign lost    = (det == KEY_NONE) || (det != r_held);

    always_comb begin
        n_ref_level  = r_ref_level;
        n_ref_button = r_ref_button;
        n_run        = r_run;
        if (!r_ref_valid) begin
            n_ref_level  = avg;
            n_ref_button = det;
            n_run        = 8'd1;
        end else if (diff <= r_stable_tol && det == r_ref_button) begin
            if (r_run != RUN_MAX) begin
                n_run = r_run + 8'd1;
            end
        end else begin
            n_ref_level  = avg;
            n_ref_button = det;
            n_run        = 8'd1;
        end

        n_state = r_state;
        n_held  = r_held;
        n_start = r_start;
        n_event = KEY_NONE;
        case (r_state)
            ST_RELEASED: begin
                if (n_run >= r_stable_ned && det != KEY_NONE) begin
                    n_state = ST_PRESSED;
                    n_start = r_b_now;
                    n_held  = det;
                    n_event = det;
                end
            end
            ST_PRESSED: begin
                if (lost) begin
                    n_state = ST_RELEASED;
                    n_held  = KEY_NONE;
                end else if (elapsed > {16'd0, r_hold_time}) begin
                    n_state = ST_HELD;
                end
            end
            default: begin
                if (lost) begin
                    n_state = ST_RELEASED;
                    n_held  = KEY_NONE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_level  <= '0;
            r_ref_valid  <= 1'b0;
            r_ref_button <= KEY_NONE;
            r_run        <= '0;
            r_state      <= ST_RELEASED;
            r_held       <= KEY_NONE;
            r_start      <= '0;
        end else if (b_adv) begin
            r_ref_level  <= n_ref_level;
            r_ref_valid  <= 1'b1;
            r_ref_button <= n_ref_button;
            r_run        <= n_run;
            r_state      <= n_state;
            r_held       <= n_held;
            r_start      <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out.press_event   <= n_event;
            r_out.key_state     <= n_state;
            r_out.active_button <= n_held;
            r_out.average_level <= avg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_released_no_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RELEASED) |-> (r_held == KEY_NONE))
        else $error("released state carries a button");

    a_pressed_has_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RELEASED) |-> (r_held != KEY_NONE))
        else $error("pressed or held state without a button");

    a_event_means_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.press_event != KEY_NONE) |->
        (o_out_data.key_state == ST_PRESSED &&
         o_out_data.active_button == o_out_data.press_event))
        else $error("press event without matching pressed state");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ref_valid |-> (r_run != 8'd0))
        else $error("stable run is zero with a valid reference");
`endif

endmodule

`default_nettype wire

// ===== tb/analog_keypad_debouncer_top_tb.sv =====
// ----------------------------------------------------------------------------
// analog_keypad_debouncer_top_tb: self-checking bench for the keypad debouncer
// Drives ADC samples through the valid/ready request channel, programs the
// settings over APB between phases, and compares every report against a
// cycle-free model of the averaging window, stability count and key machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module analog_keypad_debouncer_top_tb;
    import akd_pkg::*;

    localparam int AVG_DEPTH = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in                i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out               o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // register copies, masked to their widths
    logic [31:0] reg_shadow [8];

    // model state
    logic [11:0] window_q [AVG_DEPTH];
    int          window_slot;
    logic [14:0] window_sum;
    logic [11:0] ref_level;
    bit          ref_valid;
    logic [2:0]  ref_btn;
    logic [7:0]  stable_cnt;
    logic [1:0]  key_st;
    logic [2:0]  held_btn;
    logic [31:0] press_start;

    t_out        expected_reports [$];
    int          fail_count;
    bit          no_idle;
    logic [31:0] clock_ms;

    analog_keypad_debouncer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [2:0] decode_button(input logic [11:0] level);
        if (level > reg_shadow[REG_NONE_CUT][11:0]) return KEY_NONE;
        if (level < reg_shadow[REG_RIGHT_CUT][11:0]) return KEY_RIGHT;
        if (level < reg_shadow[REG_UP_CUT][11:0]) return KEY_UP;
        if (level < reg_shadow[REG_DOWN_CUT][11:0]) return KEY_DOWN;
        if (level < reg_shadow[REG_LEFT_CUT][11:0]) return KEY_LEFT;
        return KEY_SELECT;
    endfunction

    function automatic t_out debounce_sample(input t_in smp);
        t_out        rep;
        logic [11:0] avg;
        logic [11:0] diff;
        logic [2:0]  btn;
        logic [31:0] elapsed;
        rep = '0;
        window_sum = window_sum - 15'(window_q[window_slot]) + 15'(smp.adc_sample);
        window_q[window_slot] = smp.adc_sample;
        window_slot = (window_slot + 1) % AVG_DEPTH;
        avg = 12'(window_sum / AVG_DEPTH);
        btn = decode_button(avg);

        if (!ref_valid) begin
            ref_valid = 1'b1;
            ref_level = avg;
            ref_btn = btn;
            stable_cnt = 8'd1;
        end else begin
            diff = (avg > ref_level) ? avg - ref_level : ref_level - avg;
            if (diff <= reg_shadow[REG_STABLE_TOL][11:0] && btn == ref_btn) begin
                if (stable_cnt != RUN_MAX) stable_cnt = stable_cnt + 8'd1;
            end else begin
                stable_cnt = 8'd1;
                ref_level = avg;
                ref_btn = btn;
            end
        end

        elapsed = smp.now_ms - press_start;
        case (key_st)
            ST_RELEASED: begin
                if (stable_cnt >= reg_shadow[REG_STABLE_NED][7:0] && btn != KEY_NONE) begin
                    key_st = ST_PRESSED;
                    press_start = smp.now_ms;
                    held_btn = btn;
                    rep.press_event = btn;
                end
            end
            ST_PRESSED: begin
                if (btn == KEY_NONE || btn != held_btn) begin
                    key_st = ST_RELEASED;
                    held_btn = KEY_NONE;
                end else if (elapsed > {16'd0, reg_shadow[REG_HOLD_TIME][15:0]}) begin
                    key_st = ST_HELD;
                end
            end
            default: begin
                if (btn == KEY_NONE || btn != held_btn) begin
                    key_st = ST_RELEASED;
                    held_btn = KEY_NONE;
                end
            end
        endcase

        rep.key_state = key_st;
        rep.active_button = held_btn;
        rep.average_level = avg;
        return rep;
    endfunction

    function automatic logic [11:0] clamp_level(input int v);
        if (v < 0) return 12'd0;
        if (v > 4095) return 12'd4095;
        return 12'(v);
    endfunction

    task automatic clear_model();
        for (int k = 0; k < AVG_DEPTH; k++) window_q[k] = '0;
        window_slot = 0;
        window_sum = '0;
        ref_level = '0;
        ref_valid = 1'b0;
        ref_btn = KEY_NONE;
        stable_cnt = '0;
        key_st = ST_RELEASED;
        held_btn = KEY_NONE;
        press_start = '0;
        reg_shadow[REG_HOLD_TIME]  = {16'd0, RST_HOLD_TIME};
        reg_shadow[REG_STABLE_TOL] = {20'd0, RST_STABLE_TOL};
        reg_shadow[REG_STABLE_NED] = {24'd0, RST_STABLE_NED};
        reg_shadow[REG_NONE_CUT]   = {20'd0, RST_NONE_CUT};
        reg_shadow[REG_RIGHT_CUT]  = {20'd0, RST_RIGHT_CUT};
        reg_shadow[REG_UP_CUT]     = {20'd0, RST_UP_CUT};
        reg_shadow[REG_DOWN_CUT]   = {20'd0, RST_DOWN_CUT};
        reg_shadow[REG_LEFT_CUT]   = {20'd0, RST_LEFT_CUT};
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(input logic [11:0] adc, input logic [31:0] stamp);
        t_in item;
        int  gap;
        item.adc_sample = adc;
        item.now_ms = stamp;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (!o_in_ready);
        expected_reports.push_back(debounce_sample(item));
        @(negedge i_clk);
    endtask

    // advance the millisecond tick by a random step, occasionally a long one
    task automatic send_level(input logic [11:0] level);
        int unsigned pick;
        int unsigned step;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            step = $urandom_range(60000, 70000);
        end else if (pick < 4) begin
            step = $urandom_range(500, 2500);
        end else begin
            step = $urandom_range(0, 40);
        end
        clock_ms = clock_ms + step;
        send_sample(level, clock_ms);
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // an idle wait after each transfer keeps back-to-back calls apart
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HOLD_TIME:  reg_shadow[idx] = {16'd0, val[15:0]};
            REG_STABLE_NED: reg_shadow[idx] = {24'd0, val[7:0]};
            default:        reg_shadow[idx] = {20'd0, val[11:0]};
        endcase
        @(negedge i_clk);
    endtask

    task automatic apb_read(input logic [2:0] idx, output logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        val = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] hold, input logic [11:0] tol,
                                  input logic [7:0] needed, input logic [11:0] none_c,
                                  input logic [11:0] right_c, input logic [11:0] up_c,
                                  input logic [11:0] down_c, input logic [11:0] left_c);
        apb_write(REG_HOLD_TIME, {16'd0, hold});
        apb_write(REG_STABLE_TOL, {20'd0, tol});
        apb_write(REG_STABLE_NED, {24'd0, needed});
        apb_write(REG_NONE_CUT, {20'd0, none_c});
        apb_write(REG_RIGHT_CUT, {20'd0, right_c});
        apb_write(REG_UP_CUT, {20'd0, up_c});
        apb_write(REG_DOWN_CUT, {20'd0, down_c});
        apb_write(REG_LEFT_CUT, {20'd0, left_c});
    endtask

    // steady levels near thresholds, anywhere or at the rails, or short noise
    task automatic send_bursts(input int n);
        int          remaining;
        int          len;
        int          pick;
        int          idx;
        bit          noisy;
        logic [11:0] target;
        remaining = n;
        while (remaining > 0) begin
            no_idle = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            noisy = (pick == 9);
            if (pick < 6) begin
                idx = $urandom_range(int'(REG_NONE_CUT), int'(REG_LEFT_CUT));
                target = clamp_level(int'(reg_shadow[idx][11:0]) +
                                     int'($urandom_range(0, 6)) - 3);
            end else if (pick < 8) begin
                target = 12'($urandom_range(0, 4095));
            end else begin
                target = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            end
            if (noisy) begin
                len = $urandom_range(1, 6);
            end else if ($urandom_range(0, 3) == 0) begin
                len = int'(reg_shadow[REG_STABLE_NED][7:0]) + $urandom_range(8, 16);
            end else begin
                len = $urandom_range(1, 14);
            end
            for (int k = 0; k < len; k++) begin
                if (noisy) begin
                    send_level(12'($urandom_range(0, 4095)));
                end else begin
                    send_level(clamp_level(int'(target) + int'($urandom_range(0, 2)) - 1));
                end
                remaining--;
            end
        end
        no_idle = 1'b0;
    endtask

    // steady zero from reset must still press; hold timing across the tick wrap
    task automatic test_first_average_and_wrap();
        for (int k = 0; k < 4; k++) send_sample(12'd0, 32'hFFFF_FF00 + k);
        send_sample(12'd0, 32'h0000_0300);
        send_sample(12'd0, 32'hFFFF_FFFF);
        for (int k = 0; k < 8; k++) send_sample(12'd4095, 32'(k * 7));
        for (int k = 0; k < 8; k++) send_sample(12'd3800, 32'h8000_0000 + k);
        drain_pipeline();
    endtask

    task automatic test_register_readback();
        logic [31:0] rd;
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) begin
                for (int i = 0; i < 8; i++) apb_write(3'(i), $urandom);
            end
            for (int i = 0; i < 8; i++) begin
                apb_read(3'(i), rd);
                if (rd !== reg_shadow[i]) begin
                    $error("reg[%0d]: expected %0h, got %0h", i, reg_shadow[i], rd);
                    fail_count++;
                end
            end
        end
    endtask

    // count up to the largest threshold and past it, then a threshold of zero
    task automatic test_stable_run_limit();
        apply_settings(RST_HOLD_TIME, 12'd4095, 8'd255, RST_NONE_CUT, RST_RIGHT_CUT,
                       RST_UP_CUT, RST_DOWN_CUT, RST_LEFT_CUT);
        for (int k = 0; k < 290; k++) send_level(12'd1000);
        drain_pipeline();
        apply_settings(16'd200, 12'd0, 8'd0, RST_NONE_CUT, RST_RIGHT_CUT,
                       RST_UP_CUT, RST_DOWN_CUT, RST_LEFT_CUT);
        send_bursts(30);
        drain_pipeline();
    endtask

    task automatic test_random_settings();
        for (int s = 0; s < 7; s++) begin
            case (s)
                0: apply_settings(RST_HOLD_TIME, RST_STABLE_TOL, RST_STABLE_NED,
                                  RST_NONE_CUT, RST_RIGHT_CUT, RST_UP_CUT,
                                  RST_DOWN_CUT, RST_LEFT_CUT);
                1: apply_settings(16'd0, 12'd0, 8'd1, RST_NONE_CUT, RST_RIGHT_CUT,
                                  RST_UP_CUT, RST_DOWN_CUT, RST_LEFT_CUT);
                2: apply_settings(16'hFFFF, 12'd4095, 8'd8, RST_NONE_CUT, RST_RIGHT_CUT,
                                  RST_UP_CUT, RST_DOWN_CUT, RST_LEFT_CUT);
                3: apply_settings(16'd1000, 12'd10, 8'd2, 12'd4095, 12'd4095,
                                  12'd4095, 12'd4095, 12'd4095);
                4: apply_settings(16'd500, 12'd20, 8'd3, 12'd0, 12'd0,
                                  12'd0, 12'd0, 12'd0);
                // thresholds in any order
                default: apply_settings(16'($urandom_range(0, 3000)),
                                        12'($urandom_range(0, 64)),
                                        8'($urandom_range(1, 12)),
                                        12'($urandom_range(0, 4095)),
                                        12'($urandom_range(0, 4095)),
                                        12'($urandom_range(0, 4095)),
                                        12'($urandom_range(0, 4095)),
                                        12'($urandom_range(0, 4095)));
            endcase
            send_bursts(36);
            drain_pipeline();
        end
    endtask

    // report checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected report: %0h", o_out_data);
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                if (o_out_data.press_event !== want.press_event) begin
                    $error("press_event: expected %0d, got %0d",
                           want.press_event, o_out_data.press_event);
                    fail_count++;
                end
                if (o_out_data.key_state !== want.key_state) begin
                    $error("key_state: expected %0d, got %0d",
                           want.key_state, o_out_data.key_state);
                    fail_count++;
                end
                if (o_out_data.active_button !== want.active_button) begin
                    $error("active_button: expected %0d, got %0d",
                           want.active_button, o_out_data.active_button);
                    fail_count++;
                end
                if (o_out_data.average_level !== want.average_level) begin
                    $error("average_level: expected %0d, got %0d",
                           want.average_level, o_out_data.average_level);
                    fail_count++;
                end
            end
        end
    end

    // report side back-pressure
    initial begin
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_idle = 1'b0;
        fail_count = 0;
        clock_ms = $urandom;
        clear_model();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_first_average_and_wrap();
        test_register_readback();
        test_stable_run_limit();
        test_random_settings();

        drain_pipeline();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
